// ----- sv/vcr_pkg.sv -----
// vcr_pkg: shared types, codes and helpers for the video continuity recovery block.
// Used by the channel interfaces, the step logic, the result buffer, top level and checker.
package vcr_pkg;

	typedef enum logic [3:0] {
		OP_CLEAR          = 4'd0,
		OP_SEAL_DAMAGE    = 4'd1,
		OP_AWAIT_FALLBACK = 4'd2,
		OP_FREEZE         = 4'd3,
		OP_OBSERVE        = 4'd4,
		OP_COMPLETE       = 4'd5,
		OP_NOTE_AUDIO     = 4'd6,
		OP_NOTE_FROZEN    = 4'd7,
		OP_NOTE_VIDEO_END = 4'd8
	} opcode_t;

	typedef enum logic [5:0] {
		PH_NORMAL    = 6'b000001,
		PH_SEALED    = 6'b000010,
		PH_FALLBACK  = 6'b000100,
		PH_FROZEN    = 6'b001000,
		PH_CANDIDATE = 6'b010000,
		PH_RESTORING = 6'b100000
	} phase_t;

	// Phase codes as reported on the result channel
	localparam logic [2:0] PCODE_NORMAL    = 3'd0;
	localparam logic [2:0] PCODE_SEALED    = 3'd1;
	localparam logic [2:0] PCODE_FALLBACK  = 3'd2;
	localparam logic [2:0] PCODE_FROZEN    = 3'd3;
	localparam logic [2:0] PCODE_CANDIDATE = 3'd4;
	localparam logic [2:0] PCODE_RESTORING = 3'd5;

	typedef enum logic [2:0] {
		DEC_NONE     = 3'd0,
		DEC_PASS     = 3'd1,
		DEC_DISCARD  = 3'd2,
		DEC_REJECTED = 3'd3,
		DEC_RESTORE  = 3'd4
	} decision_t;

	// Presence flag positions
	localparam int unsigned FL_DAMAGE   = 0;
	localparam int unsigned FL_CAND     = 1;
	localparam int unsigned FL_FALLBACK = 2;
	localparam int unsigned FL_AUDIO    = 3;
	localparam int unsigned FL_FROZEN   = 4;
	localparam int unsigned FL_VIDEO    = 5;

	typedef logic [5:0] flags_t;
	typedef logic signed [63:0] time_t;
	typedef logic [63:0] track_t;

	typedef struct packed {
		phase_t phase;
		flags_t flags;
		time_t  damage_start;
		time_t  candidate_time;
		track_t fallback_track;
		time_t  audio_frontier;
		time_t  frozen_through;
		time_t  video_end;
	} vcr_state_t;

	typedef struct packed {
		decision_t  decision;
		vcr_state_t state;
	} vcr_result_t;

	localparam vcr_state_t STATE_RESET = '{
		phase:          PH_NORMAL,
		flags:          '0,
		damage_start:   '0,
		candidate_time: '0,
		fallback_track: '0,
		audio_frontier: '0,
		frozen_through: '0,
		video_end:      '0
	};

	function automatic logic [2:0] phase_code(phase_t p);
		logic [2:0] c;
		unique case (p)
			PH_NORMAL:    c = PCODE_NORMAL;
			PH_SEALED:    c = PCODE_SEALED;
			PH_FALLBACK:  c = PCODE_FALLBACK;
			PH_FROZEN:    c = PCODE_FROZEN;
			PH_CANDIDATE: c = PCODE_CANDIDATE;
			PH_RESTORING: c = PCODE_RESTORING;
			default:      c = PCODE_NORMAL;
		endcase
		return c;
	endfunction

endpackage

// ----- sv/vcr_ifs.sv -----
// vcr_ifs: valid/ready channel interfaces for event items and result items.
// Depends on vcr_pkg for the payload types.
interface vcr_evt_if;
	import vcr_pkg::*;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	time_t       time_us;
	track_t      fb_track;
	logic        sync_point;
	logic        corrupt;

	modport source(output valid, opcode, time_us, fb_track, sync_point, corrupt,
		input ready);
	modport sink(input valid, opcode, time_us, fb_track, sync_point, corrupt,
		output ready);
endinterface

interface vcr_res_if;
	import vcr_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  decision;
	logic [2:0]  phase;
	logic [5:0]  present_mask;
	time_t       damage_start_out;
	time_t       candidate_time_out;
	track_t      fallback_track_out;
	time_t       audio_frontier_out;
	time_t       frozen_through_out;
	time_t       video_end_out;

	modport source(output valid, decision, phase, present_mask, damage_start_out,
		candidate_time_out, fallback_track_out, audio_frontier_out, frozen_through_out,
		video_end_out, input ready);
	modport sink(input valid, decision, phase, present_mask, damage_start_out,
		candidate_time_out, fallback_track_out, audio_frontier_out, frozen_through_out,
		video_end_out, output ready);
endinterface

// ----- sv/vcr_step.sv -----
// vcr_step: next recovery state and decision for one event item.
// Purely combinational; depends on vcr_pkg.
module vcr_step (
	input  vcr_pkg::vcr_state_t cur,
	input  logic [3:0]          opcode,
	input  vcr_pkg::time_t      time_us,
	input  vcr_pkg::track_t     fb_track,
	input  logic                sync_point,
	input  logic                corrupt,
	output vcr_pkg::vcr_state_t nxt,
	output vcr_pkg::decision_t  decision
);
	import vcr_pkg::*;

	time_t  held_sel;
	logic   held_ok;
	time_t  max_val;

	// One shared comparator for the three running maxima
	always_comb begin
		unique case (opcode_t'(opcode))
			OP_NOTE_AUDIO: begin
				held_sel = cur.audio_frontier;
				held_ok  = cur.flags[FL_AUDIO];
			end
			OP_NOTE_FROZEN: begin
				held_sel = cur.frozen_through;
				held_ok  = cur.flags[FL_FROZEN];
			end
			default: begin
				held_sel = cur.video_end;
				held_ok  = cur.flags[FL_VIDEO];
			end
		endcase
		max_val = (held_ok && (held_sel > time_us)) ? held_sel : time_us;
	end

	always_comb begin
		nxt      = cur;
		decision = DEC_NONE;
		unique case (opcode_t'(opcode))
			OP_CLEAR: nxt = STATE_RESET;
			OP_SEAL_DAMAGE: begin
				nxt.phase = PH_SEALED;
				if (!cur.flags[FL_DAMAGE]) begin
					nxt.damage_start      = time_us;
					nxt.flags[FL_DAMAGE]  = 1'b1;
				end
				nxt.flags[FL_CAND]  = 1'b0;
				nxt.candidate_time  = '0;
			end
			OP_AWAIT_FALLBACK: begin
				nxt.phase               = PH_FALLBACK;
				nxt.fallback_track      = fb_track;
				nxt.flags[FL_FALLBACK]  = 1'b1;
			end
			OP_FREEZE: begin
				nxt.phase               = PH_FROZEN;
				nxt.flags[FL_FALLBACK]  = 1'b0;
				nxt.fallback_track      = '0;
			end
			OP_OBSERVE: begin
				priority if (cur.phase == PH_NORMAL) begin
					decision = DEC_PASS;
				end else if (corrupt) begin
					// Damaged sample: drop any candidate and fall back or freeze
					decision = (cur.phase == PH_CANDIDATE) ? DEC_REJECTED : DEC_DISCARD;
					nxt.flags[FL_CAND] = 1'b0;
					nxt.candidate_time = '0;
					nxt.phase = cur.flags[FL_FALLBACK] ? PH_FALLBACK : PH_FROZEN;
				end else if (cur.phase == PH_SEALED) begin
					decision = DEC_DISCARD;
				end else if (cur.phase == PH_FROZEN || cur.phase == PH_FALLBACK) begin
					decision = DEC_DISCARD;
					if (sync_point) begin
						nxt.candidate_time = time_us;
						nxt.flags[FL_CAND] = 1'b1;
						nxt.phase          = PH_CANDIDATE;
					end
				end else if (cur.phase == PH_CANDIDATE) begin
					if (sync_point) begin
						decision  = DEC_RESTORE;
						nxt.phase = PH_RESTORING;
					end else begin
						decision  = DEC_DISCARD;
					end
				end else begin
					decision = DEC_PASS;
				end
			end
			OP_COMPLETE: begin
				nxt.phase               = PH_NORMAL;
				nxt.flags[FL_DAMAGE]    = 1'b0;
				nxt.flags[FL_FROZEN]    = 1'b0;
				nxt.flags[FL_CAND]      = 1'b0;
				nxt.flags[FL_FALLBACK]  = 1'b0;
				nxt.damage_start        = '0;
				nxt.frozen_through      = '0;
				nxt.candidate_time      = '0;
				nxt.fallback_track      = '0;
			end
			OP_NOTE_AUDIO: begin
				nxt.audio_frontier   = max_val;
				nxt.flags[FL_AUDIO]  = 1'b1;
			end
			OP_NOTE_FROZEN: begin
				nxt.frozen_through   = max_val;
				nxt.flags[FL_FROZEN] = 1'b1;
			end
			OP_NOTE_VIDEO_END: begin
				nxt.video_end        = max_val;
				nxt.flags[FL_VIDEO]  = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/vcr_out_buf.sv -----
// vcr_out_buf: two-entry result buffer (output register plus skid register).
// Depends on vcr_pkg for the result type.
module vcr_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vcr_pkg::vcr_result_t push_data,
	output logic                 can_push,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vcr_pkg::vcr_result_t out_data
);
	import vcr_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	vcr_result_t out_q;
	vcr_result_t skid_q;
	logic        head_free;

	// Head slot can take new data when empty or being drained this cycle
	assign head_free = !out_valid_q || out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- sv/video_continuity_recovery_fsm.sv -----
// video_continuity_recovery_fsm: top level of the video continuity recovery block.
// Depends on vcr_pkg, vcr_ifs, vcr_step and vcr_out_buf.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-------------------------------------------------
//   evt     | in  | valid/ready  | opcode, time_us, fb_track, sync_point,
//           |     |              | corrupt
//   res     | out | valid/ready  | decision, phase, present_mask, six held values
//
// Every event item yields exactly one registered result item; one item per cycle
// flows through while res.ready stays high.
// The recovery state registers update at the accept edge through one level of
// step logic, and the result register captures the new state and decision.
// A skid register behind the result register lets one more item enter while a
// result is stalled; evt.ready drops only when both result slots are full.
// arst_n clears the state to phase normal, no presence flags, zero values, and
// empties both result slots.
module video_continuity_recovery_fsm (
	input logic   clk,
	input logic   arst_n,
	vcr_evt_if.sink   evt,
	vcr_res_if.source res
);
	import vcr_pkg::*;

	vcr_state_t  state_q;
	vcr_state_t  state_nxt;
	decision_t   decision;
	vcr_result_t result;
	vcr_result_t res_data;
	logic        accept;
	logic        can_push;

	// Take an item whenever the result buffer has a free slot
	assign evt.ready = can_push;
	assign accept    = evt.valid && can_push;

	vcr_step u_step (
		.cur        (state_q),
		.opcode     (evt.opcode),
		.time_us    (evt.time_us),
		.fb_track   (evt.fb_track),
		.sync_point (evt.sync_point),
		.corrupt    (evt.corrupt),
		.nxt        (state_nxt),
		.decision   (decision)
	);

	// Advance the recovery state only on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// The result reports the decision with the state after the event
	assign result.decision = decision;
	assign result.state    = state_nxt;

	vcr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.can_push  (can_push),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res_data)
	);

	// Unpack the held result onto the channel fields
	assign res.decision           = res_data.decision;
	assign res.phase              = phase_code(res_data.state.phase);
	assign res.present_mask       = res_data.state.flags;
	assign res.damage_start_out   = res_data.state.damage_start;
	assign res.candidate_time_out = res_data.state.candidate_time;
	assign res.fallback_track_out = res_data.state.fallback_track;
	assign res.audio_frontier_out = res_data.state.audio_frontier;
	assign res.frozen_through_out = res_data.state.frozen_through;
	assign res.video_end_out      = res_data.state.video_end;

endmodule

// ----- sv/vcr_checker.sv -----
// vcr_checker: port-level assertions for video_continuity_recovery_fsm, with its bind.
// Depends on vcr_pkg for decision and phase codes.
module vcr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [2:0]        decision,
	input logic [2:0]        phase,
	input logic [5:0]        present_mask,
	input vcr_pkg::time_t    damage_start_out,
	input vcr_pkg::time_t    candidate_time_out,
	input vcr_pkg::track_t   fallback_track_out
);
	import vcr_pkg::*;

	// A stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	a_restore_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && decision == DEC_RESTORE |-> phase == PCODE_RESTORING)
		else $error("restore decision outside restoring phase");

	a_reject_drops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && decision == DEC_REJECTED |->
		!present_mask[FL_CAND] && (phase == PCODE_FALLBACK || phase == PCODE_FROZEN))
		else $error("rejected candidate still held");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
		(present_mask[FL_DAMAGE] || damage_start_out == '0) &&
		(present_mask[FL_CAND] || candidate_time_out == '0) &&
		(present_mask[FL_FALLBACK] || fallback_track_out == '0))
		else $error("absent value reads nonzero");

	a_normal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && phase == PCODE_NORMAL |->
		!present_mask[FL_DAMAGE] && !present_mask[FL_CAND] && !present_mask[FL_FALLBACK])
		else $error("recovery values held in normal phase");

endmodule

bind video_continuity_recovery_fsm vcr_checker u_vcr_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.decision           (res.decision),
	.phase              (res.phase),
	.present_mask       (res.present_mask),
	.damage_start_out   (res.damage_start_out),
	.candidate_time_out (res.candidate_time_out),
	.fallback_track_out (res.fallback_track_out)
);

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for video_continuity_recovery_fsm.
// Depends on vcr_pkg and the vcr_evt_if / vcr_res_if channel interfaces; drives event
// items, predicts each result item from its own recovery model and checks it field by field.
`timescale 1ns / 100ps

module tb_top;
	import vcr_pkg::*;

	localparam time_t      T_MIN            = 64'sh8000_0000_0000_0000;
	localparam time_t      T_MAX            = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [3:0] OP_CODE_MAX      = 4'hF;
	localparam int         LONG_HOLD_CYCLES = 60;
	localparam int         SEQ_ITEMS        = 1000;
	localparam int         NOISE_ITEMS      = 300;

	// One result item as the block reports it
	typedef struct packed {
		logic [2:0] decision;
		logic [2:0] phase;
		flags_t     present_mask;
		time_t      damage_start;
		time_t      candidate_time;
		track_t     fallback_track;
		time_t      audio_frontier;
		time_t      frozen_through;
		time_t      video_end;
	} outcome_t;

	logic clk;
	logic arst_n;

	vcr_evt_if evt_ch ();
	vcr_res_if res_ch ();

	video_continuity_recovery_fsm u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	// Recovery model state, advanced at every accepted event item
	logic [2:0] rec_phase;
	flags_t     rec_flags;
	time_t      rec_damage_start;
	time_t      rec_candidate_time;
	track_t     rec_fallback_track;
	time_t      rec_audio_frontier;
	time_t      rec_frozen_through;
	time_t      rec_video_end;

	outcome_t   pending_outcomes[$];
	int         fail_count = 0;
	int         items_sent = 0;
	time_t      pts;

	// Idling knobs shared by the sender and the result-ready process
	bit         src_idle_en  = 1'b1;
	bit         sink_idle_en = 1'b1;
	bit         long_hold_req = 1'b0;

	// ------------------------------------------------------------------
	// Clock, reset and run limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10ms;
		$display("tb_top: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Recovery model
	// ------------------------------------------------------------------
	function automatic void clear_recovery();
		rec_phase          = PCODE_NORMAL;
		rec_flags          = '0;
		rec_damage_start   = '0;
		rec_candidate_time = '0;
		rec_fallback_track = '0;
		rec_audio_frontier = '0;
		rec_frozen_through = '0;
		rec_video_end      = '0;
	endfunction

	// Running maximum: take t when absent, else the signed max
	function automatic time_t running_max(time_t held, bit present, time_t t);
		if (!present)
			return t;
		return (t > held) ? t : held;
	endfunction

	function automatic outcome_t step_recovery(logic [3:0] op, time_t t, track_t track,
		logic rap, logic dmg);
		outcome_t   o;
		logic [2:0] dec;
		dec = DEC_NONE;
		case (op)
			OP_CLEAR: begin
				clear_recovery();
			end
			OP_SEAL_DAMAGE: begin
				rec_phase = PCODE_SEALED;
				// keep the first damage start
				if (!rec_flags[FL_DAMAGE]) begin
					rec_damage_start    = t;
					rec_flags[FL_DAMAGE] = 1'b1;
				end
				rec_flags[FL_CAND] = 1'b0;
				rec_candidate_time = '0;
			end
			OP_AWAIT_FALLBACK: begin
				rec_phase              = PCODE_FALLBACK;
				rec_fallback_track     = track;
				rec_flags[FL_FALLBACK] = 1'b1;
			end
			OP_FREEZE: begin
				rec_phase              = PCODE_FROZEN;
				rec_flags[FL_FALLBACK] = 1'b0;
				rec_fallback_track     = '0;
			end
			OP_OBSERVE: begin
				if (rec_phase == PCODE_NORMAL) begin
					dec = DEC_PASS;
				end else if (dmg) begin
					dec = (rec_phase == PCODE_CANDIDATE) ? DEC_REJECTED : DEC_DISCARD;
					rec_flags[FL_CAND] = 1'b0;
					rec_candidate_time = '0;
					rec_phase = rec_flags[FL_FALLBACK] ? PCODE_FALLBACK : PCODE_FROZEN;
				end else if (rec_phase == PCODE_SEALED) begin
					dec = DEC_DISCARD;
				end else if (rec_phase == PCODE_FROZEN || rec_phase == PCODE_FALLBACK) begin
					if (rap) begin
						rec_candidate_time = t;
						rec_flags[FL_CAND] = 1'b1;
						rec_phase          = PCODE_CANDIDATE;
					end
					dec = DEC_DISCARD;
				end else if (rec_phase == PCODE_CANDIDATE) begin
					if (rap) begin
						rec_phase = PCODE_RESTORING;
						dec       = DEC_RESTORE;
					end else begin
						dec = DEC_DISCARD;
					end
				end else begin
					dec = DEC_PASS;
				end
			end
			OP_COMPLETE: begin
				rec_phase              = PCODE_NORMAL;
				rec_flags[FL_DAMAGE]   = 1'b0;
				rec_flags[FL_FROZEN]   = 1'b0;
				rec_flags[FL_CAND]     = 1'b0;
				rec_flags[FL_FALLBACK] = 1'b0;
				rec_damage_start       = '0;
				rec_frozen_through     = '0;
				rec_candidate_time     = '0;
				rec_fallback_track     = '0;
			end
			OP_NOTE_AUDIO: begin
				rec_audio_frontier    = running_max(rec_audio_frontier, rec_flags[FL_AUDIO], t);
				rec_flags[FL_AUDIO]   = 1'b1;
			end
			OP_NOTE_FROZEN: begin
				rec_frozen_through    = running_max(rec_frozen_through, rec_flags[FL_FROZEN], t);
				rec_flags[FL_FROZEN]  = 1'b1;
			end
			OP_NOTE_VIDEO_END: begin
				rec_video_end         = running_max(rec_video_end, rec_flags[FL_VIDEO], t);
				rec_flags[FL_VIDEO]   = 1'b1;
			end
			default: ; // unused opcodes leave everything as is
		endcase
		o.decision       = dec;
		o.phase          = rec_phase;
		o.present_mask   = rec_flags;
		o.damage_start   = rec_damage_start;
		o.candidate_time = rec_candidate_time;
		o.fallback_track = rec_fallback_track;
		o.audio_frontier = rec_audio_frontier;
		o.frozen_through = rec_frozen_through;
		o.video_end      = rec_video_end;
		return o;
	endfunction

	initial clear_recovery();

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// Idle stretch: mostly short, now and then a long one
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned src_gap();
		if (!src_idle_en || $urandom_range(0, 2) != 0)
			return 0;
		return idle_len();
	endfunction

	function automatic time_t rand_time();
		case ($urandom_range(0, 7))
			0:       return T_MIN;
			1:       return T_MAX;
			2, 3:    return time_t'(int'($urandom_range(0, 2000)) - 1000);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic track_t rand_track();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Advance the presentation clock; sometimes jump anywhere
	function automatic time_t next_pts();
		if ($urandom_range(0, 15) == 0)
			return rand_time();
		pts = pts + time_t'($urandom_range(1, 40000));
		return pts;
	endfunction

	// ------------------------------------------------------------------
	// Event sender: leaves valid high on return, so the next item may follow
	// back to back; anything that waits afterwards must lower valid first.
	// ------------------------------------------------------------------
	task automatic send_event(logic [3:0] op, time_t t, track_t track, logic rap, logic dmg);
		int unsigned gap;
		gap = src_gap();
		if (gap != 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.opcode     <= op;
		evt_ch.time_us    <= t;
		evt_ch.fb_track   <= track;
		evt_ch.sync_point <= rap;
		evt_ch.corrupt    <= dmg;
		do @(posedge clk); while (!evt_ch.ready);
		// accepted at this edge: predict now
		pending_outcomes.push_back(step_recovery(op, t, track, rap, dmg));
		items_sent++;
	endtask

	task automatic send_op(logic [3:0] op, time_t t);
		send_event(op, t, rand_track(), rand_bit(), rand_bit());
	endtask

	task automatic send_obs(time_t t, logic rap, logic dmg);
		send_event(OP_OBSERVE, t, rand_track(), rap, dmg);
	endtask

	task automatic maybe_note();
		time_t t;
		if ($urandom_range(0, 2) != 0)
			return;
		t = ($urandom_range(0, 3) == 0) ? rand_time() : next_pts();
		case ($urandom_range(0, 2))
			0:       send_op(OP_NOTE_AUDIO, t);
			1:       send_op(OP_NOTE_FROZEN, t);
			default: send_op(OP_NOTE_VIDEO_END, t);
		endcase
	endtask

	// Hold off the sender until every predicted result has been checked
	task automatic drain_results();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Result side: ready with random stalls, plus a long hold on request
	// ------------------------------------------------------------------
	initial begin : res_ready_ctl
		int unsigned stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD_CYCLES;
			end
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len() - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result item with no pending prediction");
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("decision", want.decision, res_ch.decision);
				check_field("phase", want.phase, res_ch.phase);
				check_field("present_mask", want.present_mask, res_ch.present_mask);
				check_field("damage_start_out", want.damage_start, res_ch.damage_start_out);
				check_field("candidate_time_out", want.candidate_time,
					res_ch.candidate_time_out);
				check_field("fallback_track_out", want.fallback_track,
					res_ch.fallback_track_out);
				check_field("audio_frontier_out", want.audio_frontier,
					res_ch.audio_frontier_out);
				check_field("frozen_through_out", want.frozen_through,
					res_ch.frozen_through_out);
				check_field("video_end_out", want.video_end, res_ch.video_end_out);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Walk every opcode and the corner cases once, starting from reset state
	task automatic test_directed_cases();
		send_obs(T_MAX, 1'b1, 1'b1);                 // normal: pass whatever the flags
		send_op(OP_CODE_MAX, T_MIN);                 // unused opcode: no change
		send_op(OP_NOTE_AUDIO, T_MIN);               // first note stores even the minimum
		send_op(OP_NOTE_AUDIO, T_MAX);
		send_op(OP_NOTE_AUDIO, 64'sd0);              // maximum held
		send_op(OP_NOTE_FROZEN, -64'sd5);
		send_op(OP_NOTE_FROZEN, T_MIN);
		send_op(OP_NOTE_VIDEO_END, T_MAX);
		send_op(OP_SEAL_DAMAGE, T_MIN);
		send_op(OP_SEAL_DAMAGE, T_MAX);              // first damage start kept
		send_obs(64'sd10, 1'b1, 1'b0);               // sealed: discard
		send_event(OP_AWAIT_FALLBACK, 64'sd0, '1, 1'b0, 1'b0);
		send_obs(64'sd20, 1'b0, 1'b0);
		send_obs(T_MAX, 1'b1, 1'b0);                 // candidate found
		send_obs(64'sd30, 1'b0, 1'b0);
		send_obs(64'sd40, 1'b1, 1'b1);               // candidate rejected, back to fallback
		send_op(OP_FREEZE, 64'sd0);
		send_obs(64'sd50, 1'b0, 1'b1);               // frozen, damaged: stay frozen
		send_obs(T_MIN, 1'b1, 1'b0);
		send_obs(64'sd60, 1'b1, 1'b0);               // restore
		send_obs(64'sd70, 1'b0, 1'b0);               // restoring: pass
		send_obs(64'sd80, 1'b1, 1'b1);               // restoring, damaged: discard
		send_op(OP_COMPLETE, 64'sd0);
		send_op(OP_NOTE_VIDEO_END + 4'd1, T_MAX);    // lowest unused opcode
		send_op(OP_CLEAR, T_MAX);                    // maxima return to zero too
		drain_results();
	endtask

	// Stall the result side long enough to fill both result slots and block the input
	task automatic test_output_stall();
		src_idle_en   = 1'b0;
		sink_idle_en  = 1'b0;
		long_hold_req = 1'b1;
		repeat (16) begin
			send_obs(next_pts(), rand_bit(), $urandom_range(0, 3) == 0);
			maybe_note();
		end
		drain_results();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// One damage episode: seal, fallback or freeze, hunt for a random access point,
	// restore if one is found within the tries, then usually complete
	task automatic run_recovery_scenario();
		int unsigned tries;
		repeat ($urandom_range(0, 3)) begin
			send_obs(next_pts(), rand_bit(), rand_bit());
			maybe_note();
		end
		send_op(OP_SEAL_DAMAGE, next_pts());
		if ($urandom_range(0, 3) == 0)
			send_op(OP_SEAL_DAMAGE, rand_time());
		repeat ($urandom_range(0, 2))
			send_obs(next_pts(), rand_bit(), $urandom_range(0, 4) == 0);
		if ($urandom_range(0, 2) != 0)
			send_event(OP_AWAIT_FALLBACK, next_pts(), rand_track(),
				rand_bit(), rand_bit());
		else
			send_op(OP_FREEZE, next_pts());
		tries = 0;
		while (rec_phase != PCODE_RESTORING && tries < 20) begin
			case ($urandom_range(0, 19))
				0:       send_op(OP_FREEZE, next_pts());
				1:       send_event(OP_AWAIT_FALLBACK, next_pts(), rand_track(), 1'b0, 1'b0);
				2:       send_op(OP_SEAL_DAMAGE, next_pts());
				default: send_obs(next_pts(), $urandom_range(0, 9) < 4,
					$urandom_range(0, 6) == 0);
			endcase
			maybe_note();
			tries++;
		end
		repeat ($urandom_range(0, 4)) begin
			send_obs(next_pts(), rand_bit(), $urandom_range(0, 4) == 0);
			maybe_note();
		end
		case ($urandom_range(0, 9))
			0:       send_op(OP_CLEAR, next_pts());
			1, 2:    ; // leave the episode open; the next seal carries on
			default: send_op(OP_COMPLETE, next_pts());
		endcase
	endtask

	task automatic test_recovery_sequences();
		int unsigned mode;
		while (items_sent < SEQ_ITEMS) begin
			mode = $urandom_range(0, 19);
			src_idle_en  = (mode < 14) || (mode == 17);
			sink_idle_en = (mode < 14) || (mode == 18);
			run_recovery_scenario();
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		drain_results();
	endtask

	// Unstructured events, unused opcodes and rare clears
	task automatic test_random_events();
		logic [3:0]  op;
		int unsigned r;
		repeat (NOISE_ITEMS) begin
			r = $urandom_range(0, 39);
			if (r == 0)
				op = OP_CLEAR;
			else if (r < 4)
				op = 4'($urandom_range(OP_NOTE_VIDEO_END + 1, OP_CODE_MAX));
			else if (r < 16)
				op = OP_OBSERVE;
			else
				op = 4'($urandom_range(OP_SEAL_DAMAGE, OP_NOTE_VIDEO_END));
			send_event(op, rand_time(), rand_track(), rand_bit(), rand_bit());
		end
		drain_results();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		evt_ch.valid      <= 1'b0;
		evt_ch.opcode     <= OP_CLEAR;
		evt_ch.time_us    <= '0;
		evt_ch.fb_track   <= '0;
		evt_ch.sync_point <= 1'b0;
		evt_ch.corrupt    <= 1'b0;
		pts = time_t'($urandom_range(0, 100000));
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		test_directed_cases();
		test_output_stall();
		test_recovery_sequences();
		test_output_stall();
		test_random_events();

		// let any stray result show up before judging
		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/vcr_pkg.sv
sv/vcr_ifs.sv
sv/vcr_step.sv
sv/vcr_out_buf.sv
sv/video_continuity_recovery_fsm.sv
sv/vcr_checker.sv
test/tb_top.sv
